/* hdl/minhash_signature_top_assert.svh */
// assertion macros for the minhash signature block
// expects clk_i and rst_ni in the scope of each use
`ifndef MINHASH_SIGNATURE_TOP_ASSERT_SVH
`define MINHASH_SIGNATURE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MHSIG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MHSIG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mhsig_pkg.sv */
// shared constants and types for the minhash signature block
// no dependencies
package mhsig_pkg;

  // widths of the data path
  localparam int unsigned SHINGLE_W = 64;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned SLOT_W    = 6;

  // splitmix64 finalizer constants
  localparam logic [63:0] MIX_ADD = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_M1  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_M2  = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  // register stages in one mixer, and in the two mixers in series
  localparam int unsigned MIX_LAT = 5;
  localparam int unsigned TAG_LAT = 2 * MIX_LAT;

  // configuration register indexes
  localparam logic REG_HASH_SEED  = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  // control handed to each cell of the minimum ring
  typedef struct packed {
    logic shift;  // take the neighbor's word
    logic upd;    // fold the candidate into the word taken
    logic clear;  // return to all ones
  } cell_ctl_t;

endpackage

/* hdl/mhsig_mix.sv */
// five-stage pipelined splitmix64 finalizer
// depends on mhsig_pkg for the mix constants
module mhsig_mix import mhsig_pkg::*; (
  input  logic                 clk_i,
  input  logic [SHINGLE_W-1:0] v_i,
  output logic [SHINGLE_W-1:0] v_o
);

  logic [63:0] add_s;
  logic [63:0] x1_q, x1_d;
  logic [63:0] pa0_q, pa0_d;
  logic [31:0] pa1_q, pa1_d, pa2_q, pa2_d;
  logic [63:0] ya_s;
  logic [63:0] x3_q, x3_d;
  logic [63:0] pb0_q, pb0_d;
  logic [31:0] pb1_q, pb1_d, pb2_q, pb2_d;
  logic [63:0] yb_s;
  logic [63:0] x5_q, x5_d;

  // add golden ratio, first xor-shift
  assign add_s = v_i + MIX_ADD;
  assign x1_d  = add_s ^ (add_s >> MIX_SH1);

  // first multiply split into 32-bit partial products
  assign pa0_d = 64'(x1_q[31:0]) * 64'(MIX_M1[31:0]);
  assign pa1_d = x1_q[31:0] * MIX_M1[63:32];
  assign pa2_d = x1_q[63:32] * MIX_M1[31:0];

  // recombine mod 2^64, second xor-shift
  assign ya_s = pa0_q + {pa1_q + pa2_q, 32'h0};
  assign x3_d = ya_s ^ (ya_s >> MIX_SH2);

  // second multiply split into 32-bit partial products
  assign pb0_d = 64'(x3_q[31:0]) * 64'(MIX_M2[31:0]);
  assign pb1_d = x3_q[31:0] * MIX_M2[63:32];
  assign pb2_d = x3_q[63:32] * MIX_M2[31:0];

  // recombine mod 2^64, final xor-shift
  assign yb_s = pb0_q + {pb1_q + pb2_q, 32'h0};
  assign x5_d = yb_s ^ (yb_s >> MIX_SH3);

  // pipeline registers
  always_ff @(posedge clk_i) begin
    x1_q  <= x1_d;
    pa0_q <= pa0_d;
    pa1_q <= pa1_d;
    pa2_q <= pa2_d;
    x3_q  <= x3_d;
    pb0_q <= pb0_d;
    pb1_q <= pb1_d;
    pb2_q <= pb2_d;
    x5_q  <= x5_d;
  end

  assign v_o = x5_q;

endmodule

/* hdl/mhsig_cell.sv */
// one cell of the slot minimum ring
// depends on mhsig_pkg for the cell control struct
module mhsig_cell import mhsig_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [WORD_W-1:0] nbr_i,
  input  logic [WORD_W-1:0] cand_i,
  output logic [WORD_W-1:0] q_o
);

  logic [WORD_W-1:0] min_q, min_d;

  // on shift take the neighbor's word, or the candidate when updating and it is smaller; clear returns to all ones
  always_comb begin
    min_d = min_q;
    if (ctl_i.clear) begin
      min_d = '1;
    end else if (ctl_i.shift) begin
      if (ctl_i.upd && (cand_i < nbr_i)) begin
        min_d = cand_i;
      end else begin
        min_d = nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
    end else begin
      min_q <= min_d;
    end
  end

  assign q_o = min_q;

endmodule

/* hdl/minhash_signature_top.sv */
// top level of the minhash signature block: control, mixers and the minimum ring
// depends on mhsig_pkg, mhsig_mix, mhsig_cell and minhash_signature_top_assert.svh
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  cfg     | cfg_we_i             | cfg_idx_i, cfg_data_i
//  in      | in_valid_i/in_ready_o | shingle_i, has_shingle_i, end_of_set_i
//  out     | out_valid_o/out_ready_i | slot_index_o, min_value_o, last_word_o
//
// a word with a shingle sends every slot, one slot a cycle, through the
// shared pair of mixers, and the ring turns once as the ten-stage pipe drains.
// a bare word is taken in idle; with end of set it starts the sending of words,
// which clears the ring at once when no slot is active. one word is worked on at a time.
// out_ready_i low holds the ring and the current word; nothing else waits on it.
// reset sets every slot to all ones, seed to zero and count to 64.
module minhash_signature_top import mhsig_pkg::*; #(
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [SHINGLE_W-1:0] cfg_data_i,
  // input words
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SHINGLE_W-1:0] shingle_i,
  input  logic                 has_shingle_i,
  input  logic                 end_of_set_i,
  // signature words
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic [WORD_W-1:0]    min_value_o,
  output logic                 last_word_o
);

  `include "minhash_signature_top_assert.svh"

  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_UPDATE = 3'b010,
    ST_EMIT   = 3'b100
  } state_e;

  typedef struct packed {
    logic vld;  // a slot leaves the mixers
    logic act;  // that slot is below the active count
    logic lst;  // last slot of the pass
  } tag_t;

  state_e               state_q, state_d;
  logic [SHINGLE_W-1:0] seed_q;
  logic [COUNT_W-1:0]   count_q;
  logic [SHINGLE_W-1:0] shingle_q;
  logic                 end_q;
  logic [CNT_W-1:0]     iss_q, iss_d;
  logic                 iss_run_q, iss_run_d;
  logic [CNT_W-1:0]     emit_q, emit_d;
  tag_t                 tag_q [TAG_LAT];
  tag_t                 tag_in;
  logic [CNT_W-1:0]     n_act;
  logic                 in_acc;
  logic                 out_acc;
  logic                 clr;
  logic [SHINGLE_W-1:0] key_in, key_out, hv_in, hv_out;
  cell_ctl_t            ctl_body, ctl_tail;
  logic [WORD_W-1:0]    cell_q [MAX_SLOTS];

  // active slot count, saturated at the ring length
  assign n_act = (count_q > COUNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(count_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      count_q <= COUNT_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HASH_SEED:  seed_q  <= cfg_data_i;
        REG_HASH_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT) && (n_act != '0);
  assign out_acc     = out_valid_o && out_ready_i;

  // slot issue into the mixers
  assign tag_in.vld = (state_q == ST_UPDATE) && iss_run_q;
  assign tag_in.act = iss_q < n_act;
  assign tag_in.lst = iss_q == CNT_W'(MAX_SLOTS - 1);

  assign key_in = seed_q + SHINGLE_W'(iss_q);
  assign hv_in  = key_out ^ shingle_q;

  mhsig_mix u_key_mix (
    .clk_i (clk_i),
    .v_i   (key_in),
    .v_o   (key_out)
  );

  mhsig_mix u_hv_mix (
    .clk_i (clk_i),
    .v_i   (hv_in),
    .v_o   (hv_out)
  );

  // slot tags that travel alongside the mixers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAG_LAT; i++) begin
        tag_q[i] <= '0;
      end
    end else begin
      tag_q[0] <= tag_in;
      for (int i = 1; i < TAG_LAT; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    iss_d     = iss_q;
    iss_run_d = iss_run_q;
    emit_d    = emit_q;
    clr       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (has_shingle_i) begin
            state_d   = ST_UPDATE;
            iss_d     = '0;
            iss_run_d = 1'b1;
          end else if (end_of_set_i) begin
            state_d = ST_EMIT;
            emit_d  = '0;
          end
        end
      end
      ST_UPDATE: begin
        if (tag_in.vld) begin
          iss_d = CNT_W'(iss_q + 1'b1);
          if (tag_in.lst) begin
            iss_run_d = 1'b0;
          end
        end
        if (tag_q[TAG_LAT-1].vld && tag_q[TAG_LAT-1].lst) begin
          state_d = end_q ? ST_EMIT : ST_IDLE;
          emit_d  = '0;
        end
      end
      ST_EMIT: begin
        if (n_act == '0) begin
          clr     = 1'b1;
          state_d = ST_IDLE;
        end else if (out_acc) begin
          emit_d = CNT_W'(emit_q + 1'b1);
          if (last_word_o) begin
            clr     = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iss_q     <= '0;
      iss_run_q <= 1'b0;
      emit_q    <= '0;
    end else begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      iss_run_q <= iss_run_d;
      emit_q    <= emit_d;
    end
  end

  // word held for the duration of its pass
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      shingle_q <= shingle_i;
      end_q     <= end_of_set_i;
    end
  end

  // ring control: turns once per mixed slot and once per word sent
  assign ctl_body.shift = tag_q[TAG_LAT-1].vld || out_acc;
  assign ctl_body.upd   = 1'b0;
  assign ctl_body.clear = clr;

  assign ctl_tail.shift = ctl_body.shift;
  assign ctl_tail.upd   = tag_q[TAG_LAT-1].vld && tag_q[TAG_LAT-1].act;
  assign ctl_tail.clear = clr;

  // ring of slot minima, head at cell zero, tail closes the loop
  for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1) % MAX_SLOTS;
    mhsig_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  ((g == MAX_SLOTS - 1) ? ctl_tail : ctl_body),
      .nbr_i  (cell_q[NXT]),
      .cand_i (hv_out[SHINGLE_W-1:WORD_W]),
      .q_o    (cell_q[g])
    );
  end

  // signature word from the ring head
  assign slot_index_o = SLOT_W'(emit_q);
  assign min_value_o  = cell_q[0];
  assign last_word_o  = CNT_W'(emit_q + 1'b1) == n_act;

  // checks
  `MHSIG_ASSERT_NOW(a_ready_quiet, in_ready_o, !out_valid_o && !tag_q[TAG_LAT-1].vld, "ready while busy")
  `MHSIG_ASSERT_NEXT(a_last_to_idle, out_acc && last_word_o, in_ready_o, "no return to idle after last word")
  `MHSIG_ASSERT_NOW(a_tail_in_update, tag_q[TAG_LAT-1].vld, state_q == ST_UPDATE, "mixer result outside update")

endmodule
